// ===== hw/rtl/flv_avc_video_tag_parser_defines.svh =====
// Assertion helpers shared by the tag parser RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef FLV_AVC_VIDEO_TAG_PARSER_DEFINES_SVH
`define FLV_AVC_VIDEO_TAG_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FLVAVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FLVAVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/flvavc_pkg.sv =====
package flvavc_pkg;

    // Parse position within a tag
    typedef enum logic [4:0] {
        PH_TYPE, PH_SIZE, PH_TS, PH_TSEXT, PH_STREAM, PH_VHDR, PH_PKT,
        PH_CT_CFG, PH_CT_PAY, PH_CFGVER, PH_PROFILE, PH_COMPAT, PH_LEVEL,
        PH_LENSZ, PH_NUMSPS, PH_SPSLEN, PH_SPSDATA, PH_NUMPPS, PH_PPSLEN,
        PH_PPSDATA, PH_CHROMA, PH_LUMA, PH_CDEPTH, PH_NUMEXT, PH_PAYLOAD
    } t_phase;

    // Field identifiers on the result channel
    localparam logic [4:0] FID_TYPE       = 5'd0;
    localparam logic [4:0] FID_SIZE       = 5'd1;
    localparam logic [4:0] FID_TS         = 5'd2;
    localparam logic [4:0] FID_TSEXT      = 5'd3;
    localparam logic [4:0] FID_STREAM     = 5'd4;
    localparam logic [4:0] FID_FRAMETYPE  = 5'd5;
    localparam logic [4:0] FID_CODEC      = 5'd6;
    localparam logic [4:0] FID_PKTTYPE    = 5'd7;
    localparam logic [4:0] FID_CTIME      = 5'd8;
    localparam logic [4:0] FID_CFGVER     = 5'd9;
    localparam logic [4:0] FID_PROFILE    = 5'd10;
    localparam logic [4:0] FID_COMPAT     = 5'd11;
    localparam logic [4:0] FID_LEVEL      = 5'd12;
    localparam logic [4:0] FID_RSV1       = 5'd13;
    localparam logic [4:0] FID_LENSZ      = 5'd14;
    localparam logic [4:0] FID_RSV2       = 5'd15;
    localparam logic [4:0] FID_NUMSPS     = 5'd16;
    localparam logic [4:0] FID_SPSLEN     = 5'd17;
    localparam logic [4:0] FID_SPSBYTE    = 5'd18;
    localparam logic [4:0] FID_NUMPPS     = 5'd19;
    localparam logic [4:0] FID_PPSLEN     = 5'd20;
    localparam logic [4:0] FID_PPSBYTE    = 5'd21;
    localparam logic [4:0] FID_RSV3       = 5'd22;
    localparam logic [4:0] FID_CHROMA     = 5'd23;
    localparam logic [4:0] FID_RSV4       = 5'd24;
    localparam logic [4:0] FID_LUMA       = 5'd25;
    localparam logic [4:0] FID_RSV5       = 5'd26;
    localparam logic [4:0] FID_CDEPTH     = 5'd27;
    localparam logic [4:0] FID_NUMEXT     = 5'd28;
    localparam logic [4:0] FID_PAYLOAD    = 5'd29;
    localparam logic [4:0] FID_END        = 5'd30;

    // Stream constants
    localparam logic [3:0]  CODEC_AVC     = 4'h7;
    localparam logic [7:0]  PKT_SEQ_HDR   = 8'h00;
    localparam logic [23:0] PAY_CNT_MAX   = 24'hFF_FFFF;

    // Most results one byte can produce
    localparam int unsigned MAX_RESULTS   = 3;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [23:0] field_value;
        logic        last_result;
        logic        truncated;
    } t_result;

    // Results of one input word, item[0] goes out first
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] item;
        logic [1:0]                count;
    } t_result_set;

endpackage

// ===== hw/rtl/flvavc_in_if.sv =====
interface flvavc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// ===== hw/rtl/flvavc_out_if.sv =====
interface flvavc_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_id;
    logic [23:0] field_value;
    logic        last_result;
    logic        truncated;

    modport source (output valid, output field_id, output field_value,
                    output last_result, output truncated, input ready);
    modport sink   (input valid, input field_id, input field_value,
                    input last_result, input truncated, output ready);
endinterface

// ===== hw/rtl/flvavc_parser.sv =====
module flvavc_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    output flvavc_pkg::t_result_set o_set
);

    flvavc_pkg::t_phase r_phase, n_phase;
    logic [1:0]         r_bif, n_bif;
    logic [15:0]        r_acc, n_acc;
    logic [15:0]        r_left, n_left;
    logic [23:0]        r_pay_cnt, n_pay_cnt;

    logic [23:0]        s_v3, s_v2;
    logic               s_done3, s_done2;
    logic [15:0]        s_left_dec;
    flvavc_pkg::t_result s_r0, s_r1, s_end;
    logic [1:0]         s_cnt;

    function automatic flvavc_pkg::t_result mk(input logic [4:0] id, input logic [23:0] val);
        flvavc_pkg::t_result r;
        r.field_id    = id;
        r.field_value = val;
        r.last_result = 1'b0;
        r.truncated   = 1'b0;
        return r;
    endfunction

    // multi-byte field gathering, big endian
    assign s_v3       = {r_acc, i_byte};
    assign s_v2       = {8'h00, r_acc[7:0], i_byte};
    assign s_done3    = (r_bif == 2'd2);
    assign s_done2    = (r_bif != 2'd0);
    assign s_left_dec = r_left - 16'd1;

    // field decode and next parse state
    always_comb begin
        n_phase   = r_phase;
        n_bif     = r_bif;
        n_acc     = r_acc;
        n_left    = r_left;
        n_pay_cnt = r_pay_cnt;
        s_r0      = mk(flvavc_pkg::FID_PAYLOAD, 24'd0);
        s_r1      = mk(flvavc_pkg::FID_PAYLOAD, 24'd0);
        s_cnt     = 2'd0;
        s_end     = mk(flvavc_pkg::FID_END, 24'd0);
        o_set     = '0;

        unique case (r_phase)
            flvavc_pkg::PH_TYPE: begin
                s_r0 = mk(flvavc_pkg::FID_TYPE, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_SIZE;
            end
            flvavc_pkg::PH_SIZE, flvavc_pkg::PH_TS, flvavc_pkg::PH_STREAM,
            flvavc_pkg::PH_CT_CFG, flvavc_pkg::PH_CT_PAY: begin
                if (s_done3) begin
                    n_acc = '0;
                    n_bif = 2'd0;
                    s_cnt = 2'd1;
                    unique case (r_phase)
                        flvavc_pkg::PH_SIZE: begin
                            s_r0 = mk(flvavc_pkg::FID_SIZE, s_v3);
                            n_phase = flvavc_pkg::PH_TS;
                        end
                        flvavc_pkg::PH_TS: begin
                            s_r0 = mk(flvavc_pkg::FID_TS, s_v3);
                            n_phase = flvavc_pkg::PH_TSEXT;
                        end
                        flvavc_pkg::PH_STREAM: begin
                            s_r0 = mk(flvavc_pkg::FID_STREAM, s_v3);
                            n_phase = flvavc_pkg::PH_VHDR;
                        end
                        flvavc_pkg::PH_CT_CFG: begin
                            s_r0 = mk(flvavc_pkg::FID_CTIME, s_v3);
                            n_phase = flvavc_pkg::PH_CFGVER;
                        end
                        default: begin
                            s_r0 = mk(flvavc_pkg::FID_CTIME, s_v3);
                            n_phase = flvavc_pkg::PH_PAYLOAD;
                        end
                    endcase
                end else begin
                    n_acc = {r_acc[7:0], i_byte};
                    n_bif = r_bif + 2'd1;
                end
            end
            flvavc_pkg::PH_TSEXT: begin
                s_r0 = mk(flvavc_pkg::FID_TSEXT, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_STREAM;
            end
            flvavc_pkg::PH_VHDR: begin
                s_r0 = mk(flvavc_pkg::FID_FRAMETYPE, {20'd0, i_byte[7:4]});
                s_r1 = mk(flvavc_pkg::FID_CODEC, {20'd0, i_byte[3:0]});
                s_cnt = 2'd2;
                n_phase = (i_byte[3:0] == flvavc_pkg::CODEC_AVC) ?
                          flvavc_pkg::PH_PKT : flvavc_pkg::PH_PAYLOAD;
            end
            flvavc_pkg::PH_PKT: begin
                s_r0 = mk(flvavc_pkg::FID_PKTTYPE, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = (i_byte == flvavc_pkg::PKT_SEQ_HDR) ?
                          flvavc_pkg::PH_CT_CFG : flvavc_pkg::PH_CT_PAY;
            end
            flvavc_pkg::PH_CFGVER: begin
                s_r0 = mk(flvavc_pkg::FID_CFGVER, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_PROFILE;
            end
            flvavc_pkg::PH_PROFILE: begin
                s_r0 = mk(flvavc_pkg::FID_PROFILE, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_COMPAT;
            end
            flvavc_pkg::PH_COMPAT: begin
                s_r0 = mk(flvavc_pkg::FID_COMPAT, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_LEVEL;
            end
            flvavc_pkg::PH_LEVEL: begin
                s_r0 = mk(flvavc_pkg::FID_LEVEL, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_LENSZ;
            end
            flvavc_pkg::PH_LENSZ: begin
                s_r0 = mk(flvavc_pkg::FID_RSV1, {18'd0, i_byte[7:2]});
                s_r1 = mk(flvavc_pkg::FID_LENSZ, {22'd0, i_byte[1:0]});
                s_cnt = 2'd2;
                n_phase = flvavc_pkg::PH_NUMSPS;
            end
            flvavc_pkg::PH_NUMSPS: begin
                s_r0 = mk(flvavc_pkg::FID_RSV2, {21'd0, i_byte[7:5]});
                s_r1 = mk(flvavc_pkg::FID_NUMSPS, {19'd0, i_byte[4:0]});
                s_cnt = 2'd2;
                n_phase = flvavc_pkg::PH_SPSLEN;
            end
            flvavc_pkg::PH_SPSLEN, flvavc_pkg::PH_PPSLEN: begin
                if (s_done2) begin
                    n_acc  = '0;
                    n_bif  = 2'd0;
                    n_left = s_v2[15:0];
                    s_cnt  = 2'd1;
                    if (r_phase == flvavc_pkg::PH_SPSLEN) begin
                        s_r0 = mk(flvavc_pkg::FID_SPSLEN, s_v2);
                        n_phase = (s_v2[15:0] == 16'd0) ?
                                  flvavc_pkg::PH_NUMPPS : flvavc_pkg::PH_SPSDATA;
                    end else begin
                        s_r0 = mk(flvavc_pkg::FID_PPSLEN, s_v2);
                        n_phase = (s_v2[15:0] == 16'd0) ?
                                  flvavc_pkg::PH_CHROMA : flvavc_pkg::PH_PPSDATA;
                    end
                end else begin
                    n_acc = {r_acc[7:0], i_byte};
                    n_bif = r_bif + 2'd1;
                end
            end
            flvavc_pkg::PH_SPSDATA: begin
                s_r0 = mk(flvavc_pkg::FID_SPSBYTE, {16'd0, i_byte}); s_cnt = 2'd1;
                n_left = s_left_dec;
                if (s_left_dec == 16'd0) n_phase = flvavc_pkg::PH_NUMPPS;
            end
            flvavc_pkg::PH_NUMPPS: begin
                s_r0 = mk(flvavc_pkg::FID_NUMPPS, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_PPSLEN;
            end
            flvavc_pkg::PH_PPSDATA: begin
                s_r0 = mk(flvavc_pkg::FID_PPSBYTE, {16'd0, i_byte}); s_cnt = 2'd1;
                n_left = s_left_dec;
                if (s_left_dec == 16'd0) n_phase = flvavc_pkg::PH_CHROMA;
            end
            flvavc_pkg::PH_CHROMA: begin
                s_r0 = mk(flvavc_pkg::FID_RSV3, {18'd0, i_byte[7:2]});
                s_r1 = mk(flvavc_pkg::FID_CHROMA, {22'd0, i_byte[1:0]});
                s_cnt = 2'd2;
                n_phase = flvavc_pkg::PH_LUMA;
            end
            flvavc_pkg::PH_LUMA: begin
                s_r0 = mk(flvavc_pkg::FID_RSV4, {19'd0, i_byte[7:3]});
                s_r1 = mk(flvavc_pkg::FID_LUMA, {21'd0, i_byte[2:0]});
                s_cnt = 2'd2;
                n_phase = flvavc_pkg::PH_CDEPTH;
            end
            flvavc_pkg::PH_CDEPTH: begin
                s_r0 = mk(flvavc_pkg::FID_RSV5, {19'd0, i_byte[7:3]});
                s_r1 = mk(flvavc_pkg::FID_CDEPTH, {21'd0, i_byte[2:0]});
                s_cnt = 2'd2;
                n_phase = flvavc_pkg::PH_NUMEXT;
            end
            flvavc_pkg::PH_NUMEXT: begin
                s_r0 = mk(flvavc_pkg::FID_NUMEXT, {16'd0, i_byte}); s_cnt = 2'd1;
                n_phase = flvavc_pkg::PH_PAYLOAD;
            end
            default: begin
                // payload, and any code past it
                s_r0 = mk(flvavc_pkg::FID_PAYLOAD, {16'd0, i_byte}); s_cnt = 2'd1;
                if (r_pay_cnt != flvavc_pkg::PAY_CNT_MAX) n_pay_cnt = r_pay_cnt + 24'd1;
                n_phase = flvavc_pkg::PH_PAYLOAD;
            end
        endcase

        // end marker closes the tag; truncated if payload was never reached
        s_end.field_value = n_pay_cnt;
        s_end.last_result = 1'b1;
        s_end.truncated   = (n_phase < flvavc_pkg::PH_PAYLOAD);

        o_set.item[0] = s_r0;
        o_set.item[1] = s_r1;
        o_set.count   = s_cnt;
        if (i_last) begin
            o_set.count = s_cnt + 2'd1;
            priority case (s_cnt)
                2'd0:    o_set.item[0] = s_end;
                2'd1:    o_set.item[1] = s_end;
                default: o_set.item[2] = s_end;
            endcase
            n_phase   = flvavc_pkg::PH_TYPE;
            n_bif     = 2'd0;
            n_acc     = '0;
            n_left    = '0;
            n_pay_cnt = '0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= flvavc_pkg::PH_TYPE;
            r_bif     <= 2'd0;
            r_acc     <= '0;
            r_left    <= '0;
            r_pay_cnt <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_bif     <= n_bif;
            r_acc     <= n_acc;
            r_left    <= n_left;
            r_pay_cnt <= n_pay_cnt;
        end
    end

endmodule

// ===== hw/rtl/flv_avc_video_tag_parser.sv =====
// FLV AVC video tag parser.
// i_in (sink): one tag as a byte stream, 11 header bytes then the video data,
// last_byte set on the final byte. o_out (source): decoded fields, one per
// word, each with field_id, field_value, and on the closing end marker
// last_result (and truncated if the tag stopped before its payload).
// Each accepted byte yields zero to three result words, held in a three-entry
// result bank; the first of them is offered the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one word and
// o_out.ready stays high; a byte that yields more words holds the output port
// until its last word leaves, and a new byte is taken in the cycle that word
// leaves. The single output port, draining the bank one word per cycle, sets that rate.
// Reset (i_rst_n low, synchronous) returns the parser to the tag header type
// byte and empties the result bank. When the receiver holds o_out.ready low,
// the current word is held and no further input byte is accepted until the
// bank drains.
`include "flv_avc_video_tag_parser_defines.svh"

module flv_avc_video_tag_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    flvavc_in_if.sink   i_in,
    flvavc_out_if.source o_out
);

    flvavc_pkg::t_result_set                          s_set;
    flvavc_pkg::t_result [flvavc_pkg::MAX_RESULTS-1:0] r_bank;
    flvavc_pkg::t_result                              s_head;
    logic [1:0] r_idx, r_total;
    logic       s_in_fire, s_out_fire, s_drain;

    assign s_out_fire = o_out.valid && o_out.ready;
    assign s_drain    = s_out_fire && ((r_idx + 2'd1) == r_total);
    assign i_in.ready = (r_idx == r_total) || s_drain;
    assign s_in_fire  = i_in.valid && i_in.ready;

    flvavc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s_in_fire),
        .i_byte  (i_in.byte_value),
        .i_last  (i_in.last_byte),
        .o_set   (s_set)
    );

    // result bank and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_total <= 2'd0;
        end else if (s_in_fire) begin
            r_idx   <= 2'd0;
            r_total <= s_set.count;
        end else if (s_out_fire) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_fire) r_bank <= s_set.item;
    end

    // output word
    assign s_head            = r_bank[r_idx];
    assign o_out.valid       = (r_idx != r_total);
    assign o_out.field_id    = s_head.field_id;
    assign o_out.field_value = s_head.field_value;
    assign o_out.last_result = s_head.last_result;
    assign o_out.truncated   = s_head.truncated;

    // checks
    `FLVAVC_ASSERT_NOW(a_idx_bound, 1'b1, r_idx <= r_total, "read pointer past bank fill")
    `FLVAVC_ASSERT_NOW(a_end_is_final, o_out.valid && o_out.last_result,
        (r_idx + 2'd1) == r_total, "end marker is not the final word of its byte")
    `FLVAVC_ASSERT_NOW(a_trunc_on_end, o_out.valid && o_out.truncated,
        o_out.last_result, "truncated flag outside end marker")
    `FLVAVC_ASSERT_NEXT(a_empty_set, s_in_fire && (s_set.count == 2'd0),
        !o_out.valid, "byte with no fields produced a word")
    `FLVAVC_ASSERT_NEXT(a_last_ends, s_in_fire && i_in.last_byte,
        o_out.valid && r_bank[r_total - 2'd1].last_result,
        "last byte did not queue an end marker")

endmodule

// ===== dv/tb_flv_avc_video_tag_parser.sv =====
module tb_flv_avc_video_tag_parser;
    import flvavc_pkg::*;

    // One pending input word: tag byte, end-of-tag flag, and a request to let
    // every outstanding field drain before this byte goes out
    typedef struct packed {
        logic [7:0] value;
        logic       fin;
        logic       drain;
    } tag_byte_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    flvavc_in_if  in_bus();
    flvavc_out_if out_bus();

    flv_avc_video_tag_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser shadow state
    t_phase      tag_phase;
    logic [1:0]  field_bytes;
    logic [23:0] field_acc;
    logic [15:0] set_left;
    logic [23:0] payload_seen;

    t_result   field_queue[$];
    tag_byte_t tag_bytes[$];
    logic [7:0] tag_buf[$];

    int  errors = 0;
    int  sent_bytes = 0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  recv_calm = 0;
    int  stall_left = 0;
    bit  byte_taken = 1'b0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic void clear_parser();
        tag_phase    = PH_TYPE;
        field_bytes  = '0;
        field_acc    = '0;
        set_left     = '0;
        payload_seen = '0;
    endfunction

    function automatic void push_field(input logic [4:0] id, input logic [23:0] val);
        t_result r;
        r.field_id    = id;
        r.field_value = val;
        r.last_result = 1'b0;
        r.truncated   = 1'b0;
        field_queue.push_back(r);
    endfunction

    // Big-endian field gather; returns 1 once len bytes are in
    function automatic logic gather_field(input logic [7:0] b, input int len,
                                          output logic [23:0] val);
        field_acc = {field_acc[15:0], b};
        val = field_acc;
        if (int'(field_bytes) + 1 >= len) begin
            field_acc   = '0;
            field_bytes = '0;
            return 1'b1;
        end
        field_bytes = field_bytes + 2'd1;
        return 1'b0;
    endfunction

    // Expected fields for one tag byte
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [23:0] v;
        t_result     marker;
        case (tag_phase)
            PH_TYPE: begin
                push_field(FID_TYPE, 24'(b));
                tag_phase = PH_SIZE;
            end
            PH_SIZE: begin
                if (gather_field(b, 3, v)) begin
                    push_field(FID_SIZE, v);
                    tag_phase = PH_TS;
                end
            end
            PH_TS: begin
                if (gather_field(b, 3, v)) begin
                    push_field(FID_TS, v);
                    tag_phase = PH_TSEXT;
                end
            end
            PH_TSEXT: begin
                push_field(FID_TSEXT, 24'(b));
                tag_phase = PH_STREAM;
            end
            PH_STREAM: begin
                if (gather_field(b, 3, v)) begin
                    push_field(FID_STREAM, v);
                    tag_phase = PH_VHDR;
                end
            end
            PH_VHDR: begin
                push_field(FID_FRAMETYPE, 24'(b[7:4]));
                push_field(FID_CODEC, 24'(b[3:0]));
                tag_phase = (b[3:0] == CODEC_AVC) ? PH_PKT : PH_PAYLOAD;
            end
            PH_PKT: begin
                push_field(FID_PKTTYPE, 24'(b));
                tag_phase = (b == PKT_SEQ_HDR) ? PH_CT_CFG : PH_CT_PAY;
            end
            PH_CT_CFG, PH_CT_PAY: begin
                if (gather_field(b, 3, v)) begin
                    push_field(FID_CTIME, v);
                    tag_phase = (tag_phase == PH_CT_CFG) ? PH_CFGVER : PH_PAYLOAD;
                end
            end
            PH_CFGVER: begin
                push_field(FID_CFGVER, 24'(b));
                tag_phase = PH_PROFILE;
            end
            PH_PROFILE: begin
                push_field(FID_PROFILE, 24'(b));
                tag_phase = PH_COMPAT;
            end
            PH_COMPAT: begin
                push_field(FID_COMPAT, 24'(b));
                tag_phase = PH_LEVEL;
            end
            PH_LEVEL: begin
                push_field(FID_LEVEL, 24'(b));
                tag_phase = PH_LENSZ;
            end
            PH_LENSZ: begin
                push_field(FID_RSV1, 24'(b[7:2]));
                push_field(FID_LENSZ, 24'(b[1:0]));
                tag_phase = PH_NUMSPS;
            end
            PH_NUMSPS: begin
                push_field(FID_RSV2, 24'(b[7:5]));
                push_field(FID_NUMSPS, 24'(b[4:0]));
                tag_phase = PH_SPSLEN;
            end
            PH_SPSLEN: begin
                if (gather_field(b, 2, v)) begin
                    push_field(FID_SPSLEN, v);
                    set_left  = v[15:0];
                    tag_phase = (set_left == '0) ? PH_NUMPPS : PH_SPSDATA;
                end
            end
            PH_SPSDATA: begin
                push_field(FID_SPSBYTE, 24'(b));
                set_left = set_left - 16'd1;
                if (set_left == '0) tag_phase = PH_NUMPPS;
            end
            PH_NUMPPS: begin
                push_field(FID_NUMPPS, 24'(b));
                tag_phase = PH_PPSLEN;
            end
            PH_PPSLEN: begin
                if (gather_field(b, 2, v)) begin
                    push_field(FID_PPSLEN, v);
                    set_left  = v[15:0];
                    tag_phase = (set_left == '0) ? PH_CHROMA : PH_PPSDATA;
                end
            end
            PH_PPSDATA: begin
                push_field(FID_PPSBYTE, 24'(b));
                set_left = set_left - 16'd1;
                if (set_left == '0) tag_phase = PH_CHROMA;
            end
            PH_CHROMA: begin
                push_field(FID_RSV3, 24'(b[7:2]));
                push_field(FID_CHROMA, 24'(b[1:0]));
                tag_phase = PH_LUMA;
            end
            PH_LUMA: begin
                push_field(FID_RSV4, 24'(b[7:3]));
                push_field(FID_LUMA, 24'(b[2:0]));
                tag_phase = PH_CDEPTH;
            end
            PH_CDEPTH: begin
                push_field(FID_RSV5, 24'(b[7:3]));
                push_field(FID_CDEPTH, 24'(b[2:0]));
                tag_phase = PH_NUMEXT;
            end
            PH_NUMEXT: begin
                push_field(FID_NUMEXT, 24'(b));
                tag_phase = PH_PAYLOAD;
            end
            default: begin
                push_field(FID_PAYLOAD, 24'(b));
                if (payload_seen != PAY_CNT_MAX) payload_seen = payload_seen + 24'd1;
                tag_phase = PH_PAYLOAD;
            end
        endcase

        // End marker closes the tag, partial field is dropped
        if (fin) begin
            marker.field_id    = FID_END;
            marker.field_value = payload_seen;
            marker.last_result = 1'b1;
            marker.truncated   = (tag_phase < PH_PAYLOAD);
            field_queue.push_back(marker);
            clear_parser();
        end
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stimulus building
    task automatic put_rand(input int n);
        for (int i = 0; i < n; i++) tag_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_header(input bit rnd, input logic [7:0] fill);
        for (int i = 0; i < 11; i++)
            tag_buf.push_back(rnd ? 8'($urandom_range(0, 255)) : fill);
    endtask

    // Set length (big-endian) followed by n data bytes
    task automatic put_set(input logic [15:0] len, input int n);
        tag_buf.push_back(len[15:8]);
        tag_buf.push_back(len[7:0]);
        put_rand(n);
    endtask

    // Queue the first cut bytes of the built tag (all when cut is 0)
    task automatic send_tag(input int cut, input bit drain);
        tag_byte_t w;
        int        n;
        n = (cut <= 0 || cut > tag_buf.size()) ? tag_buf.size() : cut;
        for (int i = 0; i < n; i++) begin
            w.value = tag_buf[i];
            w.fin   = (i == n - 1);
            w.drain = drain && (i == 0);
            tag_bytes.push_back(w);
        end
        sent_bytes += n;
        tag_buf.delete();
    endtask

    function automatic logic [15:0] pick_set_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 85) return 16'($urandom_range(1, 6));
        if (r < 93) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // One random tag: mostly well-formed, some noise, some cut short
    task automatic random_tag();
        int          r;
        int          cut;
        bit          drain;
        logic [3:0]  codec;
        logic [7:0]  pkt;
        logic [15:0] len;
        drain = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            put_rand($urandom_range(1, 24));
            send_tag(0, drain);
            return;
        end
        put_header(1'b1, 8'h00);
        codec = ($urandom_range(0, 99) < 65) ? CODEC_AVC : 4'($urandom_range(0, 15));
        tag_buf.push_back({4'($urandom_range(0, 15)), codec});
        if (codec == CODEC_AVC) begin
            pkt = ($urandom_range(0, 99) < 60) ? PKT_SEQ_HDR : 8'($urandom_range(0, 255));
            tag_buf.push_back(pkt);
            put_rand(3);
            if (pkt == PKT_SEQ_HDR) begin
                put_rand(6);
                // long sets are always cut inside their data
                len = pick_set_len();
                if (len > 16'd8) begin
                    put_set(len, $urandom_range(0, 3));
                    send_tag(0, drain);
                    return;
                end
                put_set(len, int'(len));
                put_rand(1);
                len = pick_set_len();
                if (len > 16'd8) begin
                    put_set(len, $urandom_range(0, 3));
                    send_tag(0, drain);
                    return;
                end
                put_set(len, int'(len));
                put_rand(4);
            end
        end
        put_rand($urandom_range(0, 6));
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, tag_buf.size()) : 0;
        send_tag(cut, drain);
    endtask

    // Byte driver
    always @(negedge i_clk) begin : drive_bytes
        tag_byte_t nxt;
        if (i_rst_n && (!in_bus.valid || byte_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (tag_bytes.size() != 0 &&
                         !(tag_bytes[0].drain && field_queue.size() != 0)) begin
                nxt = tag_bytes.pop_front();
                in_bus.valid      <= 1'b1;
                in_bus.byte_value <= nxt.value;
                in_bus.last_byte  <= nxt.fin;
                send_gap = pick_idle(send_calm);
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_idle(recv_calm);
            out_bus.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // Monitor: check each field word, then predict from the accepted byte
    always @(posedge i_clk) begin : watch_fields
        t_result want;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (field_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word id %0d value %0h",
                                              out_bus.field_id, out_bus.field_value));
                end else begin
                    want = field_queue.pop_front();
                    if (out_bus.field_id !== want.field_id)
                        report_mismatch($sformatf("field_id got %0d want %0d",
                                                  out_bus.field_id, want.field_id));
                    if (out_bus.field_value !== want.field_value)
                        report_mismatch($sformatf("id %0d field_value got %0h want %0h",
                                                  want.field_id, out_bus.field_value,
                                                  want.field_value));
                    if (out_bus.last_result !== want.last_result)
                        report_mismatch($sformatf("id %0d last_result got %0b want %0b",
                                                  want.field_id, out_bus.last_result,
                                                  want.last_result));
                    if (out_bus.truncated !== want.truncated)
                        report_mismatch($sformatf("id %0d truncated got %0b want %0b",
                                                  want.field_id, out_bus.truncated,
                                                  want.truncated));
                end
            end
            byte_taken = in_bus.valid && in_bus.ready;
            if (byte_taken) decode_byte(in_bus.byte_value, in_bus.last_byte);
        end
    end

    // Run limit
    initial begin
        #4000000;
        $display("[flv_avc_video_tag_parser] ERROR");
        $finish;
    end

    initial begin
        in_bus.valid      = 1'b0;
        in_bus.byte_value = 8'h00;
        in_bus.last_byte  = 1'b0;
        out_bus.ready     = 1'b0;
        clear_parser();

        // Non-AVC codec, all-ones header, payload extremes
        put_header(1'b0, 8'hFF);
        tag_buf.push_back(8'hF2);
        tag_buf.push_back(8'h00);
        tag_buf.push_back(8'hFF);
        send_tag(0, 1'b0);

        // AVC NALU: composition time then payload, all-zero header
        put_header(1'b0, 8'h00);
        tag_buf.push_back({4'h1, CODEC_AVC});
        tag_buf.push_back(8'h01);
        put_rand(0);
        tag_buf.push_back(8'hFF);
        tag_buf.push_back(8'hFF);
        tag_buf.push_back(8'hFF);
        tag_buf.push_back(8'h5A);
        send_tag(0, 1'b0);

        // Sequence header: empty SPS, one PPS byte, trailer, payload;
        // sender waits for the bank to drain first
        put_header(1'b1, 8'h00);
        tag_buf.push_back({4'h1, CODEC_AVC});
        tag_buf.push_back(PKT_SEQ_HDR);
        put_rand(3 + 4);
        tag_buf.push_back(8'hFF);
        tag_buf.push_back(8'hE1);
        put_set(16'd0, 0);
        tag_buf.push_back(8'h01);
        put_set(16'd1, 1);
        put_rand(4);
        tag_buf.push_back(8'hA5);
        send_tag(0, 1'b1);

        // Sequence header ending right after the trailer, no payload
        put_header(1'b1, 8'h00);
        tag_buf.push_back({4'h2, CODEC_AVC});
        tag_buf.push_back(PKT_SEQ_HDR);
        put_rand(3 + 4);
        tag_buf.push_back(8'h00);
        tag_buf.push_back(8'h00);
        put_set(16'd2, 2);
        tag_buf.push_back(8'h00);
        put_set(16'd0, 0);
        put_rand(4);
        send_tag(0, 1'b0);

        // Tag of one byte
        tag_buf.push_back(8'h09);
        send_tag(0, 1'b0);

        // Cut inside the size field
        put_rand(3);
        send_tag(0, 1'b0);

        // Cut on the frame type/codec byte: two fields plus end marker
        put_header(1'b1, 8'h00);
        tag_buf.push_back({4'h1, CODEC_AVC});
        send_tag(0, 1'b0);

        // Maximum SPS length, cut inside the set data
        put_header(1'b1, 8'h00);
        tag_buf.push_back({4'h1, CODEC_AVC});
        tag_buf.push_back(PKT_SEQ_HDR);
        put_rand(3 + 6);
        put_set(16'hFFFF, 2);
        send_tag(0, 1'b0);

        // Cut on the luma depth byte of the trailer
        put_header(1'b1, 8'h00);
        tag_buf.push_back({4'h1, CODEC_AVC});
        tag_buf.push_back(PKT_SEQ_HDR);
        put_rand(3 + 6);
        put_set(16'd0, 0);
        put_rand(1);
        put_set(16'd0, 0);
        put_rand(2);
        send_tag(0, 1'b0);

        // Random tags fill up the byte budget
        while (sent_bytes < 210) random_tag();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (tag_bytes.size() != 0 || in_bus.valid || field_queue.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (field_queue.size() != 0)
            report_mismatch($sformatf("%0d fields never arrived", field_queue.size()));

        if (errors == 0) begin
            $display("[flv_avc_video_tag_parser] OK");
        end else begin
            $display("[flv_avc_video_tag_parser] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/flvavc_pkg.sv
hw/rtl/flvavc_in_if.sv
hw/rtl/flvavc_out_if.sv
hw/rtl/flvavc_parser.sv
hw/rtl/flv_avc_video_tag_parser.sv
dv/tb_flv_avc_video_tag_parser.sv
